/* src/sem_pkg.sv */
// Shared constants and types for the Sobel RGB edge magnitude block.
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int FW_W       = 11;
    localparam int CFG_W      = 12;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int GRAD_W     = CH_W + 2;
    localparam int GSUM_W     = CH_W + 4;
    localparam int SUM_W      = 2 * GRAD_W + 1;
    localparam int SQ_W       = 2 * CH_W;
    localparam int STEP_W     = $clog2(CH_W);
    localparam int SAT_SUM    = (2 ** CH_W - 1) * (2 ** CH_W);
    localparam int FW_RESET   = 640;
    localparam int FH_RESET   = 480;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_WAIT,
        ST_PUT
    } top_state_t;

    typedef enum logic [2:0] {
        MAG_IDLE,
        MAG_SQ,
        MAG_LOAD,
        MAG_ROOT,
        MAG_DONE
    } mag_state_t;

endpackage

/* src/sem_pix_if.sv */
// Input pixel channel: valid/ready with one RGB pixel.
interface sem_pix_if import sem_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

/* src/sem_res_if.sv */
// Result channel: valid/ready with one magnitude pixel and its position.
interface sem_res_if import sem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_run;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_row, output out_col, output last_of_run, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_row, input out_col, input last_of_run, output ready);
endinterface

/* src/sem_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* src/sem_mag.sv */
// One channel's magnitude: squares, then a bit-serial square root and rounding.
module sem_mag import sem_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [GRAD_W-1:0] ax,
    input  logic [GRAD_W-1:0] ay,
    output logic [CH_W-1:0]   mag,
    output logic              done
);
    mag_state_t          phase_reg, phase_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                done_reg, done_next;
    logic [GRAD_W-1:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]     s_reg, s_next;
    logic                sat_reg, sat_next;
    logic [CH_W+1:0]     rem_reg, rem_next;
    logic [CH_W-1:0]     root_reg, root_next;
    logic [CH_W-1:0]     mag_reg, mag_next;
    logic [CH_W+3:0]     rem2, trial;
    logic                ge;
    logic [CH_W-1:0]     rounded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MAG_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        sum_reg  <= sum_next;
        s_reg    <= s_next;
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        mag_reg  <= mag_next;
    end

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        sum_next   = sum_reg;
        s_next     = s_reg;
        sat_next   = sat_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        mag_next   = mag_reg;

        // two radicand bits enter per step, one root bit leaves
        rem2    = {rem_reg, s_reg[SQ_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = (rem2 >= trial);
        rounded = root_reg + CH_W'(rem_reg > {2'b00, root_reg});

        case (phase_reg)
            MAG_IDLE:
            begin
                if (start)
                begin
                    ax_next    = ax;
                    ay_next    = ay;
                    phase_next = MAG_SQ;
                end
            end
            MAG_SQ:
            begin
                sum_next   = SUM_W'(ax_reg) * SUM_W'(ax_reg)
                           + SUM_W'(ay_reg) * SUM_W'(ay_reg);
                phase_next = MAG_LOAD;
            end
            MAG_LOAD:
            begin
                s_next     = sum_reg[SQ_W-1:0];
                sat_next   = (sum_reg > SUM_W'(SAT_SUM));
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                phase_next = MAG_ROOT;
            end
            MAG_ROOT:
            begin
                rem_next  = ge ? (CH_W+2)'(rem2 - trial) : rem2[CH_W+1:0];
                root_next = {root_reg[CH_W-2:0], ge};
                s_next    = {s_reg[SQ_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CH_W - 1))
                begin
                    phase_next = MAG_DONE;
                end
            end
            MAG_DONE:
            begin
                mag_next   = sat_reg ? {CH_W{1'b1}} : rounded;
                done_next  = 1'b1;
                phase_next = MAG_IDLE;
            end
            default:
            begin
                phase_next = MAG_IDLE;
            end
        endcase
    end

    assign mag  = mag_reg;
    assign done = done_reg;

    a_done_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == MAG_DONE) |=> (done_reg && phase_reg == MAG_IDLE))
        else $error("magnitude done not raised after rounding");
    a_root_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == MAG_LOAD) |=> (phase_reg == MAG_ROOT && step_reg == '0))
        else $error("root iteration did not start at step zero");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && phase_reg == MAG_IDLE) |=> (phase_reg == MAG_SQ))
        else $error("start not taken");
endmodule

/* src/sobel_edge_magnitude_rgb_top.sv */
// Top level: line stores, 3x3 window, gradients and result sequencing.
//
//  Port        Role     Request carries
//  pixel       sink     in_red, in_green, in_blue
//  result      source   out_red, out_green, out_blue, out_row, out_col, last_of_run
//  write_en    config   reg_index, write_data (frame_width, frame_height)
//
// Each pixel reads the line stores and updates the window; each of its 0 to 4 results
// then takes gradients, roots and the output load; the eight-step square root dominates.
// The three channels run their square roots side by side.
// Reset clears counters, window and config to 640x480; line stores are not cleared.
// A new pixel is taken while the last result still waits in the output register.
module sobel_edge_magnitude_rgb_top import sem_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    sem_pix_if.sink           pixel,
    sem_res_if.source         result,
    input  logic              write_en,
    input  cfg_reg_t          reg_index,
    input  logic [CFG_W-1:0]  write_data
);
    top_state_t          state_reg, state_next;
    logic [FW_W-1:0]     fw_reg, fw_next;
    logic [ROW_W-1:0]    fh_reg, fh_next;
    logic [ROW_W-1:0]    row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]    col_cnt_reg, col_cnt_next;
    logic [3:0]          pend_reg, pend_next;
    logic [PIX_W-1:0]    win_reg [3][3];
    logic [PIX_W-1:0]    win_next [3][3];
    logic                out_valid_reg, out_valid_next;

    logic [PIX_W-1:0]    px_reg, px_next;
    logic [ROW_W-1:0]    i_reg, i_next;
    logic [COL_W-1:0]    j_reg, j_next;
    logic [CH_W-1:0]     ored_reg, ored_next, ogrn_reg, ogrn_next, oblu_reg, oblu_next;
    logic [ROW_W-1:0]    orow_reg, orow_next;
    logic [COL_W-1:0]    ocol_reg, ocol_next;
    logic                olast_reg, olast_next;

    logic [FW_W-1:0]     w_eff;
    logic [ROW_W-1:0]    h_eff, hl, ic;
    logic [COL_W-1:0]    wl, jc;
    logic                accept, load;
    logic [1:0]          sel;
    logic [3:0]          rest;
    logic [3:0]          rowv, colv;
    logic [1:0]          wr, wc;
    logic [PIX_W-1:0]    nb [3][3];
    logic [GSUM_W-1:0]   gx [3];
    logic [GSUM_W-1:0]   gy [3];
    logic [GSUM_W-1:0]   ngx [3];
    logic [GSUM_W-1:0]   ngy [3];
    logic [GRAD_W-1:0]   ax [3];
    logic [GRAD_W-1:0]   ay [3];
    logic [CH_W-1:0]     mag [3];
    logic                done [3];
    logic                mag_start;
    logic [PIX_W-1:0]    up2, up1;
    logic                ram_we;

    // frame size as used: zero means one, width capped at the store depth
    always_comb
    begin
        w_eff = (fw_reg == '0) ? FW_W'(1)
              : (fw_reg > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_reg;
        h_eff = (fh_reg == '0) ? ROW_W'(1) : fh_reg;
        wl    = COL_W'(w_eff - 1'b1);
        hl    = h_eff - 1'b1;
        ic    = (row_cnt_reg > hl) ? hl : row_cnt_reg;
        jc    = (col_cnt_reg > wl) ? wl : col_cnt_reg;
    end

    assign accept       = pixel.valid && pixel.ready;
    assign pixel.ready  = (state_reg == ST_IDLE);
    assign load         = (state_reg == ST_PUT) && (!out_valid_reg || result.ready);
    assign ram_we       = (state_reg == ST_LOAD);
    assign mag_start    = (state_reg == ST_GRAD);

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (ram_we),
        .waddr (j_reg),
        .wdata (up1),
        .raddr (jc),
        .rdata (up2)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (ram_we),
        .waddr (j_reg),
        .wdata (px_reg),
        .raddr (jc),
        .rdata (up1)
    );

    // first pending result in raster order
    always_comb
    begin
        if (pend_reg[0])
        begin
            sel = 2'd0;
        end
        else if (pend_reg[1])
        begin
            sel = 2'd1;
        end
        else if (pend_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
        rest = pend_reg & ~(4'b0001 << sel);
    end

    // neighborhood of the selected output pixel, zero outside the frame
    always_comb
    begin
        rowv = {1'b0, 1'b1, (i_reg >= ROW_W'(1)), (i_reg >= ROW_W'(2))};
        colv = {1'b0, 1'b1, (j_reg >= COL_W'(1)), (j_reg >= COL_W'(2))};
        wr   = '0;
        wc   = '0;
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                wr = 2'(a) + {1'b0, sel[1]};
                wc = 2'(b) + {1'b0, sel[0]};
                if (rowv[wr] && colv[wc])
                begin
                    nb[a][b] = win_reg[wr][wc];
                end
                else
                begin
                    nb[a][b] = '0;
                end
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            gx[c] = GSUM_W'(nb[0][2][c*CH_W +: CH_W])
                  + (GSUM_W'(nb[1][2][c*CH_W +: CH_W]) << 1)
                  + GSUM_W'(nb[2][2][c*CH_W +: CH_W])
                  - GSUM_W'(nb[0][0][c*CH_W +: CH_W])
                  - (GSUM_W'(nb[1][0][c*CH_W +: CH_W]) << 1)
                  - GSUM_W'(nb[2][0][c*CH_W +: CH_W]);
            gy[c] = GSUM_W'(nb[2][0][c*CH_W +: CH_W])
                  + (GSUM_W'(nb[2][1][c*CH_W +: CH_W]) << 1)
                  + GSUM_W'(nb[2][2][c*CH_W +: CH_W])
                  - GSUM_W'(nb[0][0][c*CH_W +: CH_W])
                  - (GSUM_W'(nb[0][1][c*CH_W +: CH_W]) << 1)
                  - GSUM_W'(nb[0][2][c*CH_W +: CH_W]);
            ngx[c] = -gx[c];
            ngy[c] = -gy[c];
            ax[c]  = gx[c][GSUM_W-1] ? ngx[c][GRAD_W-1:0] : gx[c][GRAD_W-1:0];
            ay[c]  = gy[c][GSUM_W-1] ? ngy[c][GRAD_W-1:0] : gy[c][GRAD_W-1:0];
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        sem_mag u_mag (
            .clk   (clk),
            .rst_n (rst_n),
            .start (mag_start),
            .ax    (ax[c]),
            .ay    (ay[c]),
            .mag   (mag[c]),
            .done  (done[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fw_reg        <= FW_W'(FW_RESET);
            fh_reg        <= ROW_W'(FH_RESET);
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    win_reg[a][b] <= '0;
                end
            end
        end
        else
        begin
            state_reg     <= state_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            win_reg       <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        ored_reg  <= ored_next;
        ogrn_reg  <= ogrn_next;
        oblu_reg  <= oblu_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        pend_next      = pend_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ored_next      = ored_reg;
        ogrn_next      = ogrn_reg;
        oblu_next      = oblu_reg;
        orow_next      = orow_reg;
        ocol_next      = ocol_reg;
        olast_next     = olast_reg;

        if (write_en)
        begin
            case (reg_index)
                REG_FRAME_WIDTH:  fw_next = write_data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_next = write_data[ROW_W-1:0];
                default:          fh_next = fh_reg;
            endcase
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    px_next   = {pixel.in_blue, pixel.in_green, pixel.in_red};
                    i_next    = ic;
                    j_next    = jc;
                    // bit index is 2*row_step + col_step
                    pend_next = {(ic == hl) && (jc == wl), (ic == hl) && (jc != '0),
                                 (ic != '0) && (jc == wl), (ic != '0) && (jc != '0)};
                    if (jc == wl)
                    begin
                        col_cnt_next = '0;
                        row_cnt_next = (ic == hl) ? '0 : ic + 1'b1;
                    end
                    else
                    begin
                        col_cnt_next = jc + 1'b1;
                        row_cnt_next = ic;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    win_next[a][0] = win_reg[a][1];
                    win_next[a][1] = win_reg[a][2];
                end
                win_next[0][2] = up2;
                win_next[1][2] = up1;
                win_next[2][2] = px_reg;
                state_next = (pend_reg == '0) ? ST_IDLE : ST_GRAD;
            end
            ST_GRAD:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (done[0])
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    ored_next      = mag[0];
                    ogrn_next      = mag[1];
                    oblu_next      = mag[2];
                    orow_next      = sel[1] ? i_reg : i_reg - 1'b1;
                    ocol_next      = sel[0] ? j_reg : j_reg - 1'b1;
                    olast_next     = (rest == '0);
                    pend_next      = rest;
                    state_next     = (rest == '0) ? ST_IDLE : ST_GRAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.valid       = out_valid_reg;
    assign result.out_red     = ored_reg;
    assign result.out_green   = ogrn_reg;
    assign result.out_blue    = oblu_reg;
    assign result.out_row     = orow_reg;
    assign result.out_col     = ocol_reg;
    assign result.last_of_run = olast_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.ready |-> (pend_reg == '0))
        else $error("pixel taken while results pending");
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOAD))
        else $error("accepted pixel did not load window");
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (done[0] == done[1]) && (done[1] == done[2]))
        else $error("channel magnitude units out of step");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (load && rest == '0) |=> (pend_reg == '0 && result.last_of_run))
        else $error("last result did not close the run");
endmodule
